FILE: rtl/wes_pkg.sv
// Shared types and constants of the wave equation stencil step block.
// Used by the register file, the controller, the datapath and the top level.
package wes_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int CFG_DIM_W = 11;
  localparam int COEF_W    = 48;
  localparam int DATA_W    = 32;
  localparam int VEL_W     = 14;

  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = ($clog2(MAX_DIM + 1) > CFG_DIM_W) ? $clog2(MAX_DIM + 1) : CFG_DIM_W;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAP_COEF    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_COEF    = 2'd3;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 112;
  localparam int SUM_W  = DATA_W + 1;
  localparam int BASE_W = DATA_W + 2;
  localparam int LAP_W  = DATA_W + 3;
  localparam int MAG_W  = DATA_W + 2;
  localparam int VSQ_W  = 2 * VEL_W;
  localparam int X_W    = MAG_W + VSQ_W;
  localparam int TMAG_W = 41;
  localparam int TERM_W = TMAG_W + 1;
  localparam int RES_W  = TERM_W + 2;

  localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (COEF_W - 1);
  localparam logic [TMAG_W-1:0] TERM_CLAMP = TMAG_W'(1) << (TMAG_W - 1);

  typedef enum logic [2:0] {
    A_VEL,
    A_MAG_LO,
    A_MAG_HI,
    A_X_LO,
    A_X_HI,
    A_SRC
  } a_sel_e;

  typedef enum logic [2:0] {
    B_VEL,
    B_VSQ,
    B_LAP_LO,
    B_LAP_HI,
    B_SRC_LO,
    B_SRC_HI
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_BIAS,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] grid_width;
    logic [CFG_DIM_W-1:0] grid_height;
    logic [COEF_W-1:0]    lap_coef;
    logic [COEF_W-1:0]    src_coef;
  } wes_cfg_t;

  typedef struct packed {
    logic    latch;
    logic    mem_rd;
    logic    wb;
    logic    lap_ld;
    logic    cap_vsq;
    logic    cap_x;
    logic    cap_t1;
    logic    cap_t2;
    logic    out_ld;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic [1:0] acc_sh;
  } wes_cmd_t;

  typedef struct packed {
    logic emit;
    logic boundary;
  } wes_sts_t;

endpackage

FILE: rtl/wave_equation_stencil_step.sv
// Streaming five-point stencil step of the 2-D acoustic wave equation.
// An interior point passes the read, write-back, Laplacian, product and output states
// before the next acceptance, while the shared 32x32 multiplier steps through the
// velocity-squared, Laplacian and source products. A boundary point skips the products,
// a first-row point the output too. Reset clears the counters, the window register,
// the configuration to its defaults and all handshake state; the line stores are not cleared.
module wave_equation_stencil_step import wes_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] curr_value_i,
  input  logic signed [DATA_W-1:0] prev_value_i,
  input  logic        [VEL_W-1:0]  velocity_i,
  input  logic signed [DATA_W-1:0] source_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] next_value_o,
  output logic                     is_boundary_o,
  output logic                     frame_last_o
);

  wes_cfg_t cfg;
  wes_cmd_t cmd;
  wes_sts_t sts;

  wes_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wes_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .curr_value_i   (curr_value_i),
    .prev_value_i   (prev_value_i),
    .velocity_i     (velocity_i),
    .source_value_i (source_value_i),
    .sts_o          (sts),
    .next_value_o   (next_value_o),
    .is_boundary_o  (is_boundary_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

FILE: rtl/wes_regs.sv
// APB register file holding grid size and the two Q0.48 coefficients.
// Depends on wes_pkg for register indexes and the configuration struct.
module wes_regs import wes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output wes_cfg_t            cfg_o
);

  wes_cfg_t cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= CFG_DIM_W'(MAX_WIDTH);
      cfg_q.grid_height <= CFG_DIM_W'(MAX_HEIGHT);
      cfg_q.lap_coef    <= '0;
      cfg_q.src_coef    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[CFG_DIM_W-1:0];
        REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[CFG_DIM_W-1:0];
        REG_LAP_COEF:    cfg_q.lap_coef    <= pwdata[COEF_W-1:0];
        REG_SRC_COEF:    cfg_q.src_coef    <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = PDATA_W'(cfg_q.grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(cfg_q.grid_height);
      REG_LAP_COEF:    prdata = PDATA_W'(cfg_q.lap_coef);
      REG_SRC_COEF:    prdata = PDATA_W'(cfg_q.src_coef);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/wes_ctrl.sv
// Sequencer of the stencil step: handshakes, memory access and multiply schedule.
// Depends on wes_pkg for the command and status structs.
module wes_ctrl import wes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  wes_sts_t sts_i,
  output wes_cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_WB   = 5'd2;
  localparam logic [4:0] S_LAP  = 5'd3;
  localparam logic [4:0] S_X0   = 5'd4;
  localparam logic [4:0] S_X1   = 5'd5;
  localparam logic [4:0] S_X2   = 5'd6;
  localparam logic [4:0] S_X3   = 5'd7;
  localparam logic [4:0] S_X4   = 5'd8;
  localparam logic [4:0] S_T0   = 5'd9;
  localparam logic [4:0] S_T1   = 5'd10;
  localparam logic [4:0] S_T2   = 5'd11;
  localparam logic [4:0] S_T3   = 5'd12;
  localparam logic [4:0] S_T4   = 5'd13;
  localparam logic [4:0] S_T5   = 5'd14;
  localparam logic [4:0] S_S1   = 5'd15;
  localparam logic [4:0] S_S2   = 5'd16;
  localparam logic [4:0] S_S3   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0] state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        if (!sts_i.emit) begin
          state_d = S_IDLE;
        end else if (sts_i.boundary) begin
          state_d = S_OUT;
        end else begin
          state_d = S_LAP;
        end
      end
      S_LAP: begin
        cmd_o.lap_ld = 1'b1;
        cmd_o.a_sel  = A_VEL;
        cmd_o.b_sel  = B_VEL;
        state_d = S_X0;
      end
      S_X0: begin
        cmd_o.cap_vsq = 1'b1;
        state_d = S_X1;
      end
      S_X1: begin
        cmd_o.a_sel = A_MAG_LO;
        cmd_o.b_sel = B_VSQ;
        state_d = S_X2;
      end
      S_X2: begin
        cmd_o.a_sel  = A_MAG_HI;
        cmd_o.b_sel  = B_VSQ;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.acc_sh = 2'd0;
        state_d = S_X3;
      end
      S_X3: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd1;
        state_d = S_X4;
      end
      S_X4: begin
        cmd_o.cap_x  = 1'b1;
        cmd_o.acc_op = ACC_BIAS;
        state_d = S_T0;
      end
      S_T0: begin
        cmd_o.a_sel = A_X_LO;
        cmd_o.b_sel = B_LAP_LO;
        state_d = S_T1;
      end
      S_T1: begin
        cmd_o.a_sel  = A_X_LO;
        cmd_o.b_sel  = B_LAP_HI;
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd0;
        state_d = S_T2;
      end
      S_T2: begin
        cmd_o.a_sel  = A_X_HI;
        cmd_o.b_sel  = B_LAP_LO;
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd1;
        state_d = S_T3;
      end
      S_T3: begin
        cmd_o.a_sel  = A_X_HI;
        cmd_o.b_sel  = B_LAP_HI;
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd1;
        state_d = S_T4;
      end
      S_T4: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd2;
        state_d = S_T5;
      end
      S_T5: begin
        cmd_o.cap_t1 = 1'b1;
        cmd_o.acc_op = ACC_BIAS;
        cmd_o.a_sel  = A_SRC;
        cmd_o.b_sel  = B_SRC_LO;
        state_d = S_S1;
      end
      S_S1: begin
        cmd_o.a_sel  = A_SRC;
        cmd_o.b_sel  = B_SRC_HI;
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd0;
        state_d = S_S2;
      end
      S_S2: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.acc_sh = 2'd1;
        state_d = S_S3;
      end
      S_S3: begin
        cmd_o.cap_t2 = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("Result register overwritten while its beat is still pending.");

  a_math_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAP) |-> (sts_i.emit && !sts_i.boundary))
    else $error("Stencil arithmetic started for a point that is not interior.");

  a_out_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> sts_i.emit)
    else $error("Result produced for an input of the first row.");

endmodule

FILE: rtl/wes_dp.sv
// Datapath of the stencil step: position counters, line stores, shared multiplier,
// accumulator and result register. Depends on wes_pkg.
module wes_dp import wes_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wes_cmd_t                 cmd_i,
  input  wes_cfg_t                 cfg_i,
  input  logic signed [DATA_W-1:0] curr_value_i,
  input  logic signed [DATA_W-1:0] prev_value_i,
  input  logic        [VEL_W-1:0]  velocity_i,
  input  logic signed [DATA_W-1:0] source_value_i,
  output wes_sts_t                 sts_o,
  output logic signed [DATA_W-1:0] next_value_o,
  output logic                     is_boundary_o,
  output logic                     frame_last_o
);

  typedef struct packed {
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] prev;
    logic [VEL_W-1:0]  vel;
    logic [DATA_W-1:0] src;
  } aux_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(MIN_DIM)) begin
      return DIM_W'(MIN_DIM);
    end else if (ve > lim) begin
      return lim;
    end
    return ve;
  endfunction

  logic [DIM_W-1:0] width_lim, height_lim;
  logic [ADDR_W-1:0] col_q, pos_col_q, start_col, right_addr;
  logic [ROW_W-1:0]  row_q, pos_row_q, start_row;
  logic [DIM_W-1:0]  row_inc, orow, col_ext, pos_col_ext, next_col, next_row;
  logic emit_q, bnd_q, last_q;
  logic [DATA_W-1:0] left_q;

  logic [DATA_W-1:0] cur_q, prv_q, src_q;
  logic [VEL_W-1:0]  vel_q;

  logic [DATA_W-1:0] center_mem [MAX_WIDTH];
  aux_t              aux_mem    [MAX_WIDTH];
  logic [DATA_W-1:0] mid_rd_q, right_rd_q;
  aux_t              aux_rd_q;

  logic signed [SUM_W-1:0]  sum_a_q, sum_b_q;
  logic signed [BASE_W-1:0] base_q;
  logic signed [LAP_W-1:0]  lap_q;
  logic [MAG_W-1:0]         lapmag_q;
  logic                     lapneg_q, srcneg_q;
  logic [DATA_W-1:0]        srcmag_q;
  logic [VSQ_W-1:0]         vsq_q;
  logic [X_W-1:0]           x_q;

  logic [MUL_W-1:0]  a_op, b_op;
  logic [PROD_W-1:0] pp_q;
  logic [ACC_W-1:0]  acc_q, pp_sh;
  logic [TMAG_W-1:0] tmag;
  logic signed [TERM_W-1:0] term_pos, term_lap, term_src;
  logic signed [RES_W-1:0]  res_q;
  logic [RES_W-DATA_W:0]    res_top;
  logic [DATA_W-1:0]        sat_val;

  logic [DATA_W-1:0] next_value_q;
  logic is_boundary_q, frame_last_q;

  assign width_lim  = clamp_dim(cfg_i.grid_width, DIM_W'(MAX_WIDTH));
  assign height_lim = clamp_dim(cfg_i.grid_height, DIM_W'(MAX_HEIGHT));

  // A counter left outside a shrunken grid wraps before the point is placed.
  always_comb begin
    col_ext = DIM_W'(col_q);
    if (col_ext >= width_lim) begin
      start_col = '0;
      row_inc   = DIM_W'(row_q) + DIM_W'(1);
    end else begin
      start_col = col_q;
      row_inc   = DIM_W'(row_q);
    end
    start_row = (row_inc >= height_lim) ? '0 : row_inc[ROW_W-1:0];
  end

  assign pos_col_ext = DIM_W'(pos_col_q);
  assign orow        = DIM_W'(pos_row_q) - DIM_W'(1);
  assign next_col    = pos_col_ext + DIM_W'(1);
  assign next_row    = DIM_W'(pos_row_q) + DIM_W'(1);
  assign right_addr  = pos_col_q + ADDR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pos_col_q <= '0;
      pos_row_q <= '0;
      emit_q    <= 1'b0;
      bnd_q     <= 1'b0;
      last_q    <= 1'b0;
      left_q    <= '0;
    end else begin
      if (cmd_i.latch) begin
        pos_col_q <= start_col;
        pos_row_q <= start_row;
      end
      if (cmd_i.mem_rd) begin
        emit_q <= (pos_row_q != '0);
        bnd_q  <= (orow == '0) || (orow >= height_lim - DIM_W'(1)) ||
                  (pos_col_q == '0) || (pos_col_ext >= width_lim - DIM_W'(1));
        last_q <= (orow == height_lim - DIM_W'(2)) &&
                  (pos_col_ext == width_lim - DIM_W'(1));
      end
      if (cmd_i.wb) begin
        left_q <= mid_rd_q;
        if (next_col >= width_lim) begin
          col_q <= '0;
          row_q <= (next_row >= height_lim) ? '0 : next_row[ROW_W-1:0];
        end else begin
          col_q <= next_col[ADDR_W-1:0];
          row_q <= pos_row_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cur_q <= curr_value_i;
      prv_q <= prev_value_i;
      vel_q <= velocity_i;
      src_q <= source_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      mid_rd_q   <= center_mem[pos_col_q];
      right_rd_q <= center_mem[right_addr];
      aux_rd_q   <= aux_mem[pos_col_q];
    end
    if (cmd_i.wb) begin
      center_mem[pos_col_q] <= cur_q;
      aux_mem[pos_col_q]    <= '{above: mid_rd_q, prev: prv_q, vel: vel_q, src: src_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      sum_a_q  <= SUM_W'($signed(right_rd_q)) + SUM_W'($signed(left_q));
      sum_b_q  <= SUM_W'($signed(aux_rd_q.above)) + SUM_W'($signed(cur_q));
      base_q   <= (BASE_W'($signed(mid_rd_q)) <<< 1) - BASE_W'($signed(aux_rd_q.prev));
      srcneg_q <= aux_rd_q.src[DATA_W-1];
      srcmag_q <= aux_rd_q.src[DATA_W-1] ? (~aux_rd_q.src + DATA_W'(1)) : aux_rd_q.src;
    end
    if (cmd_i.lap_ld) begin
      lap_q <= LAP_W'(sum_a_q) + LAP_W'(sum_b_q) - (LAP_W'($signed(mid_rd_q)) <<< 2);
    end
    if (cmd_i.cap_vsq) begin
      vsq_q    <= pp_q[VSQ_W-1:0];
      lapneg_q <= lap_q[LAP_W-1];
      lapmag_q <= lap_q[LAP_W-1] ? MAG_W'(-lap_q) : lap_q[MAG_W-1:0];
    end
    if (cmd_i.cap_x) begin
      x_q <= acc_q[X_W-1:0];
    end
  end

  always_comb begin
    case (cmd_i.a_sel)
      A_VEL:    a_op = MUL_W'(aux_rd_q.vel);
      A_MAG_LO: a_op = lapmag_q[MUL_W-1:0];
      A_MAG_HI: a_op = MUL_W'(lapmag_q[MAG_W-1:MUL_W]);
      A_X_LO:   a_op = x_q[MUL_W-1:0];
      A_X_HI:   a_op = MUL_W'(x_q[X_W-1:MUL_W]);
      A_SRC:    a_op = srcmag_q;
      default:  a_op = '0;
    endcase
    case (cmd_i.b_sel)
      B_VEL:    b_op = MUL_W'(aux_rd_q.vel);
      B_VSQ:    b_op = MUL_W'(vsq_q);
      B_LAP_LO: b_op = cfg_i.lap_coef[MUL_W-1:0];
      B_LAP_HI: b_op = MUL_W'(cfg_i.lap_coef[COEF_W-1:MUL_W]);
      B_SRC_LO: b_op = cfg_i.src_coef[MUL_W-1:0];
      B_SRC_HI: b_op = MUL_W'(cfg_i.src_coef[COEF_W-1:MUL_W]);
      default:  b_op = '0;
    endcase
    case (cmd_i.acc_sh)
      2'd0:    pp_sh = ACC_W'(pp_q);
      2'd1:    pp_sh = ACC_W'(pp_q) << MUL_W;
      2'd2:    pp_sh = ACC_W'(pp_q) << (2 * MUL_W);
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pp_q <= PROD_W'(a_op) * PROD_W'(b_op);
    case (cmd_i.acc_op)
      ACC_BIAS: acc_q <= ROUND_BIAS;
      ACC_LOAD: acc_q <= pp_sh;
      ACC_ADD:  acc_q <= acc_q + pp_sh;
      default:  acc_q <= acc_q;
    endcase
  end

  // The accumulator holds the product plus half an LSB; bits above the binary
  // point form the rounded term, whose magnitude is limited to 2^40.
  always_comb begin
    if ((|acc_q[ACC_W-1:COEF_W+TMAG_W]) ||
        (acc_q[COEF_W+TMAG_W-1] && (|acc_q[COEF_W+TMAG_W-2:COEF_W]))) begin
      tmag = TERM_CLAMP;
    end else begin
      tmag = acc_q[COEF_W+TMAG_W-1:COEF_W];
    end
    term_pos = $signed({1'b0, tmag});
    term_lap = lapneg_q ? -term_pos : term_pos;
    term_src = srcneg_q ? -term_pos : term_pos;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_t1) begin
      res_q <= RES_W'(base_q) + RES_W'(term_lap);
    end else if (cmd_i.cap_t2) begin
      res_q <= res_q + RES_W'(term_src);
    end
  end

  always_comb begin
    res_top = res_q[RES_W-1:DATA_W-1];
    if ((&res_top) || !(|res_top)) begin
      sat_val = res_q[DATA_W-1:0];
    end else if (res_q[RES_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      next_value_q  <= bnd_q ? '0 : sat_val;
      is_boundary_q <= bnd_q;
      frame_last_q  <= last_q;
    end
  end

  assign sts_o.emit     = emit_q;
  assign sts_o.boundary = bnd_q;
  assign next_value_o   = $signed(next_value_q);
  assign is_boundary_o  = is_boundary_q;
  assign frame_last_o   = frame_last_q;

endmodule
